// ----- sv/box_blur_3x3_rgb_core_assert.svh -----
// Assertion macros for the 3x3 box blur core.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BB3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BB3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bb3_pkg.sv -----
// Shared types and constants of the 3x3 box blur core.
// No dependencies; the interfaces and modules of the block refer to it by scoped names.
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned SUM_W  = 12;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  // Register index, decoded from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_in_run;
    logic             frame_done;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic sum;
    logic out;
    logic ysel;
    logic xsel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic has_y0;
    logic has_y1;
    logic has_x0;
    logic has_x1;
    logic out_free;
  } status_t;

endpackage

// ----- sv/bb3_stream_if.sv -----
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on bb3_pkg for the payload types.
`timescale 1ns / 1ps

interface bb3_pix_if;
  logic        valid;
  logic        ready;
  bb3_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bb3_res_if;
  logic        valid;
  logic        ready;
  bb3_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/box_blur_3x3_rgb_core.sv -----
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, the stream interfaces, bb3_regs, bb3_ctrl, bb3_dp and the assertion header.
//
// Usage:
//   pix_i carries raster-order RGB pixels (valid/ready); a transfer takes one pixel.
//   res_o carries blurred pixels tagged with row and column; each pixel is sent
//   once its 3x3 neighborhood has arrived, so one input yields zero to four results,
//   the last one flagged by last_in_run, and the frame's final pixel by frame_done.
//   The APB port holds image_width (0x0) and image_height (0x4); a write restarts
//   the frame at row 0, column 0. Write only while the block is idle.
// Timing:
//   After a transfer the sequencer passes the load, sum and output states before the
//   first result is valid. An input is handled in steps: the line memory is read at
//   the transfer, the window is loaded, then per result the masked sums are taken and
//   the reciprocal divide writes the output register.
//   The next pixel is taken while the last result still waits in the output register.
//   A stalled receiver holds the result steady and holds the sequencer back.
// Reset: clears counters and sequencer; sizes return to 1024 x 1024. The line
//   memory needs no clearing, as every neighbor read was written in the same frame.
`timescale 1ns / 1ps
`include "box_blur_3x3_rgb_core_assert.svh"

module box_blur_3x3_rgb_core #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bb3_pix_if.sink                    pix_i,
  bb3_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bb3_pkg::APB_AW-1:0] paddr,
  input  logic [bb3_pkg::APB_DW-1:0] pwdata,
  output logic [bb3_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CW-1:0]    last_col;
  logic [RW-1:0]    last_row;
  logic             restart;
  logic             in_ready;
  bb3_pkg::cmd_t    cmd;
  bb3_pkg::status_t status;

  bb3_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .last_col_o (last_col),
    .last_row_o (last_row),
    .restart_o  (restart)
  );

  bb3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bb3_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i.data),
    .cmd_i       (cmd),
    .restart_i   (restart),
    .last_col_i  (last_col),
    .last_row_i  (last_row),
    .status_o    (status),
    .res_o       (res_o.data),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready)
  );

  assign pix_i.ready = in_ready;

  `BB3_ASSERT_NXT(a_accept_then_load, pix_i.valid && pix_i.ready, cmd.load, "window load missed after pixel transfer")
  `BB3_ASSERT_IMP(a_no_overwrite, cmd.out, !res_o.valid || res_o.ready, "output register overwritten while stalled")
  `BB3_ASSERT_IMP(a_done_is_last, res_o.valid && res_o.data.frame_done, res_o.data.last_in_run, "frame end not flagged as last result")

endmodule

// ----- sv/bb3_regs.sv -----
// APB register file of the box blur core: frame width and height.
// Depends on bb3_pkg; delivers clamped last column/row and a frame restart pulse.
`timescale 1ns / 1ps

module bb3_regs #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::APB_AW-1:0]  paddr,
  input  logic [bb3_pkg::APB_DW-1:0]  pwdata,
  output logic [bb3_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [$clog2(MAX_WIDTH)-1:0] last_col_o,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] last_row_o,
  output logic                        restart_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [bb3_pkg::CFG_W-1:0] width_q;
  logic [bb3_pkg::CFG_W-1:0] height_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  // Any register write starts a new frame.
  assign restart_o = wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::DIM_RESET;
      height_q <= bb3_pkg::DIM_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[bb3_pkg::CFG_W-1:0];
        bb3_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[bb3_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bb3_pkg::REG_IMAGE_WIDTH:  prdata = bb3_pkg::APB_DW'(width_q);
      bb3_pkg::REG_IMAGE_HEIGHT: prdata = bb3_pkg::APB_DW'(height_q);
      default:                   prdata = '0;
    endcase
  end

  // A dimension of zero acts as one; one above the maximum acts as the maximum.
  always_comb begin
    if (width_q == '0) begin
      last_col_o = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      last_col_o = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_o = CW'(width_q - 1'b1);
    end
  end

  always_comb begin
    if (height_q == '0) begin
      last_row_o = '0;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      last_row_o = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_o = RW'(height_q - 1'b1);
    end
  end

endmodule

// ----- sv/bb3_ctrl.sv -----
// Controller of the box blur core: accepts a pixel, loads the window and then
// steps through the up to four results it completes. Depends on bb3_pkg.
`timescale 1ns / 1ps

module bb3_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bb3_pkg::status_t status_i,
  output bb3_pkg::cmd_t    cmd_o
);

  bb3_pkg::state_e state_q, state_d;
  logic            ysel_q, ysel_d;
  logic            xsel_q, xsel_d;
  logic            any_slot;
  logic            next_x;
  logic            next_y;
  logic            has_next;

  // Results go rows outer (previous row, then last row), columns inner.
  assign any_slot = (status_i.has_y0 || status_i.has_y1) &&
                    (status_i.has_x0 || status_i.has_x1);
  assign next_x   = !xsel_q && status_i.has_x1;
  assign next_y   = !ysel_q && status_i.has_y1;
  assign has_next = next_x || next_y;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bb3_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bb3_pkg::ST_LOAD;
      end
      bb3_pkg::ST_LOAD: begin
        state_d = any_slot ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
      end
      bb3_pkg::ST_SUM: begin
        state_d = bb3_pkg::ST_OUT;
      end
      bb3_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          state_d = has_next ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
        end
      end
      default: state_d = bb3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ysel_d = ysel_q;
    xsel_d = xsel_q;
    if (state_q == bb3_pkg::ST_LOAD) begin
      ysel_d = !status_i.has_y0;
      xsel_d = !status_i.has_x0;
    end else if (state_q == bb3_pkg::ST_OUT && status_i.out_free && has_next) begin
      if (next_x) begin
        xsel_d = 1'b1;
      end else begin
        ysel_d = 1'b1;
        xsel_d = !status_i.has_x0;
      end
    end
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.ysel   = ysel_q;
    cmd_o.xsel   = xsel_q;
    cmd_o.last   = !has_next;
    case (state_q)
      bb3_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bb3_pkg::ST_LOAD: cmd_o.load = 1'b1;
      bb3_pkg::ST_SUM:  cmd_o.sum  = 1'b1;
      bb3_pkg::ST_OUT:  cmd_o.out  = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bb3_pkg::ST_IDLE;
      ysel_q  <= 1'b0;
      xsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ysel_q  <= ysel_d;
      xsel_q  <= xsel_d;
    end
  end

endmodule

// ----- sv/bb3_dp.sv -----
// Datapath of the box blur core: raster counters, two-row line memory, 3x3 window,
// masked neighborhood sums, reciprocal divide and output register. Depends on bb3_pkg.
`timescale 1ns / 1ps

module bb3_dp #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bb3_pkg::pix_t                pix_i,
  input  bb3_pkg::cmd_t                cmd_i,
  input  logic                         restart_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] last_col_i,
  input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] last_row_i,
  output bb3_pkg::status_t             status_o,
  output bb3_pkg::res_t                res_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i
);

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CH_W   = bb3_pkg::CH_W;
  localparam int unsigned PIX_W  = bb3_pkg::PIX_W;
  localparam int unsigned SUM_W  = bb3_pkg::SUM_W;
  localparam int unsigned PROD_W = SUM_W + 13;
  // floor(s/3) = (s*2731)>>13 and floor(s/9) = (s*7282)>>16 hold for all s below 8192.
  localparam int unsigned RECIP3    = 2731;
  localparam int unsigned RECIP3_SH = 13;
  localparam int unsigned RECIP9    = 7282;
  localparam int unsigned RECIP9_SH = 16;

  function automatic logic [CH_W-1:0] div_by_n(input logic [SUM_W-1:0] s,
                                               input logic [3:0]       n);
    logic [PROD_W-1:0] p3;
    logic [PROD_W-1:0] p9;
    logic [SUM_W-1:0]  q3;
    logic [SUM_W-1:0]  q;
    p3 = PROD_W'(s) * PROD_W'(RECIP3);
    p9 = PROD_W'(s) * PROD_W'(RECIP9);
    q3 = SUM_W'(p3 >> RECIP3_SH);
    case (n)
      4'd1:    q = s;
      4'd2:    q = s >> 1;
      4'd3:    q = q3;
      4'd4:    q = s >> 2;
      4'd6:    q = q3 >> 1;
      4'd9:    q = SUM_W'(p9 >> RECIP9_SH);
      default: q = s;
    endcase
    return CH_W'(q);
  endfunction

  function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] p, input int unsigned k);
    return p[PIX_W-1-k*CH_W -: CH_W];
  endfunction

  logic [CW-1:0]       col_cnt_q;
  logic [RW-1:0]       row_cnt_q;
  logic [CW-1:0]       pos_c_q;
  logic [RW-1:0]       pos_r_q;
  logic [PIX_W-1:0]    pix_q;
  logic [2*PIX_W-1:0]  rd_q;
  logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic [CH_W-1:0]     win_q [3][3][3];
  logic [SUM_W-1:0]    sum_q [3];
  logic [SUM_W-1:0]    sum_d [3];
  logic [2:0]          rmask;
  logic [2:0]          cmask;
  logic [1:0]          rcnt;
  logic [1:0]          ccnt;
  logic [3:0]          n_q, n_d;
  logic [RW-1:0]       y_q, y_d;
  logic [CW-1:0]       x_q, x_d;
  logic                last_q;
  logic                done_q, done_d;
  bb3_pkg::res_t       res_q;
  logic                res_vld_q;

  // Raster position of the next pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (restart_i) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      if (col_cnt_q == last_col_i) begin
        col_cnt_q <= '0;
        row_cnt_q <= (row_cnt_q == last_row_i) ? '0 : row_cnt_q + 1'b1;
      end else begin
        col_cnt_q <= col_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_c_q <= col_cnt_q;
      pos_r_q <= row_cnt_q;
      pix_q   <= pix_i;
    end
  end

  // Line memory: upper half holds row r-2, lower half row r-1 of each column.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_q <= line_mem[col_cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) line_mem[pos_c_q] <= {rd_q[PIX_W-1:0], pix_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[i][0][k] <= win_q[i][1][k];
          win_q[i][1][k] <= win_q[i][2][k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        win_q[0][2][k] <= chan(rd_q[2*PIX_W-1:PIX_W], k);
        win_q[1][2][k] <= chan(rd_q[PIX_W-1:0], k);
        win_q[2][2][k] <= chan(pix_q, k);
      end
    end
  end

  // Window rows are r-2..r and columns c-2..c; masks keep the in-frame neighbors.
  always_comb begin
    rmask[0] = !cmd_i.ysel && (pos_r_q > RW'(1));
    rmask[1] = cmd_i.ysel ? (pos_r_q != '0) : 1'b1;
    rmask[2] = 1'b1;
    cmask[0] = !cmd_i.xsel && (pos_c_q > CW'(1));
    cmask[1] = cmd_i.xsel ? (pos_c_q != '0) : 1'b1;
    cmask[2] = 1'b1;
    rcnt = {1'b0, rmask[0]} + {1'b0, rmask[1]} + 2'd1;
    ccnt = {1'b0, cmask[0]} + {1'b0, cmask[1]} + 2'd1;
    n_d  = {2'b00, rcnt} * {2'b00, ccnt};
    y_d  = cmd_i.ysel ? pos_r_q : pos_r_q - 1'b1;
    x_d  = cmd_i.xsel ? pos_c_q : pos_c_q - 1'b1;
    done_d = (y_d == last_row_i) && (x_d == last_col_i);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (rmask[i] && cmask[j]) sum_d[k] = sum_d[k] + SUM_W'(win_q[i][j][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sum_q  <= sum_d;
      n_q    <= n_d;
      y_q    <= y_d;
      x_q    <= x_d;
      last_q <= cmd_i.last;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (cmd_i.out) begin
      res_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      res_q.red_out     <= div_by_n(sum_q[0], n_q);
      res_q.green_out   <= div_by_n(sum_q[1], n_q);
      res_q.blue_out    <= div_by_n(sum_q[2], n_q);
      res_q.out_row     <= bb3_pkg::POS_W'(y_q);
      res_q.out_col     <= bb3_pkg::POS_W'(x_q);
      res_q.last_in_run <= last_q;
      res_q.frame_done  <= done_q;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

  assign status_o.has_y0   = (pos_r_q != '0);
  assign status_o.has_y1   = (pos_r_q == last_row_i);
  assign status_o.has_x0   = (pos_c_q != '0);
  assign status_o.has_x1   = (pos_c_q == last_col_i);
  assign status_o.out_free = !res_vld_q || res_ready_i;

endmodule
